### rtl/msrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrs_pkg
// Shared types and constants for the macro sheet record screen.
// ----------------------------------------------------------------------------
package msrs_pkg;

    // Width of the stream position counter
    localparam int POSITION_BITS = 32;
    localparam int START_BITS    = POSITION_BITS + 1;
    localparam int DUE_BITS      = POSITION_BITS + 2;

    // Record window and look-ahead
    localparam int WINDOW_LEN = 15;
    localparam int LOOK_AHEAD = 14;

    // Record header fields
    localparam logic [7:0] TYPE_END   = 8'h0A;
    localparam logic [7:0] TYPE_SHEET = 8'h85;
    localparam logic [7:0] NAME_MARK  = 8'h21;
    localparam logic [7:0] SHEET_KIND = 8'h05;
    localparam int HEADER_LEN = 4;

    // Result fields
    localparam int OFFSET_BITS = 32;
    localparam logic [7:0] MASK_RESET = 8'h01;

    // Result queue depth
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        CAUSE_END    = 2'd0,
        CAUSE_SHEET  = 2'd1,
        CAUSE_STREAM = 2'd2
    } t_cause;

    typedef struct packed {
        logic                   suspect;
        t_cause                 cause;
        logic [OFFSET_BITS-1:0] record_offset;
    } t_result;

    // Write side of the result queue
    typedef struct packed {
        logic    push;
        t_result data;
    } t_push;

endpackage

### rtl/msrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrs_front
// Accepts stream bytes, tracks the record chain and classifies each record.
// ----------------------------------------------------------------------------
module msrs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data,
    input  logic                 i_last,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_data,
    output msrs_pkg::t_push      o_push
);

    localparam logic [msrs_pkg::POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [msrs_pkg::DUE_BITS-1:0] DUE_RESET =
        msrs_pkg::DUE_BITS'(msrs_pkg::LOOK_AHEAD);
    localparam logic [msrs_pkg::START_BITS-1:0] START_MAX = '1;

    logic [msrs_pkg::POSITION_BITS-1:0] r_pos, n_pos;
    logic [msrs_pkg::START_BITS-1:0]    r_start, n_start;
    logic [msrs_pkg::DUE_BITS-1:0]      r_due, n_due;
    logic                               r_done, n_done;
    logic [7:0]                         r_mask;
    logic [7:0]                         r_win [msrs_pkg::WINDOW_LEN];

    logic                               w_due;
    logic                               w_end;
    logic                               w_sheet;
    logic [15:0]                        w_len;
    logic [msrs_pkg::DUE_BITS-1:0]      w_next;
    logic [msrs_pkg::DUE_BITS-1:0]      w_next_due;

    // Mask register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= msrs_pkg::MASK_RESET;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_data;
        end
    end

    // Window shift line; the record bytes 0..12 sit one place up before the shift
    always_ff @(posedge i_clk) begin
        if (i_accept && !r_done) begin
            for (int k = 0; k < msrs_pkg::WINDOW_LEN - 1; k++) begin
                r_win[k] <= r_win[k+1];
            end
            r_win[msrs_pkg::WINDOW_LEN-1] <= i_data;
        end
    end

    // Classify the record whose look-ahead byte arrives with this beat
    always_comb begin
        w_due   = (r_pos != POS_MAX) && ({2'b00, r_pos} == r_due);
        w_end   = (r_win[1] == msrs_pkg::TYPE_END) && (r_win[2] == 8'h00);
        w_sheet = (r_win[1] == msrs_pkg::TYPE_SHEET) && (r_win[2] == 8'h00) &&
                  ((r_win[10] & r_mask) != 8'h00) &&
                  (r_win[11] == msrs_pkg::SHEET_KIND) &&
                  ((r_win[12] == msrs_pkg::NAME_MARK) ||
                   (r_win[13] == msrs_pkg::NAME_MARK));
        w_len   = {r_win[4], r_win[3]};
        w_next  = {1'b0, r_start} + msrs_pkg::DUE_BITS'(msrs_pkg::HEADER_LEN) +
                  msrs_pkg::DUE_BITS'(w_len);
        w_next_due = {1'b0, r_start} +
                     msrs_pkg::DUE_BITS'(msrs_pkg::HEADER_LEN + msrs_pkg::LOOK_AHEAD) +
                     msrs_pkg::DUE_BITS'(w_len);
    end

    // Result for the queue
    always_comb begin
        o_push.push = i_accept && !r_done && ((w_due && (w_end || w_sheet)) || i_last);
        o_push.data.suspect = 1'b0;
        priority if (w_due && w_end) begin
            o_push.data.cause         = msrs_pkg::CAUSE_END;
            o_push.data.record_offset = msrs_pkg::OFFSET_BITS'(r_start);
        end else if (w_due && w_sheet) begin
            o_push.data.suspect       = 1'b1;
            o_push.data.cause         = msrs_pkg::CAUSE_SHEET;
            o_push.data.record_offset = msrs_pkg::OFFSET_BITS'(r_start);
        end else begin
            // Stream ended undecided: report its length
            o_push.data.cause         = msrs_pkg::CAUSE_STREAM;
            o_push.data.record_offset = (r_pos == POS_MAX) ?
                msrs_pkg::OFFSET_BITS'(POS_MAX) :
                msrs_pkg::OFFSET_BITS'(r_pos + msrs_pkg::POSITION_BITS'(1));
        end
    end

    // Next chain state
    always_comb begin
        n_pos   = r_pos;
        n_start = r_start;
        n_due   = r_due;
        n_done  = r_done;
        if (i_accept) begin
            if (r_pos != POS_MAX) begin
                n_pos = r_pos + msrs_pkg::POSITION_BITS'(1);
            end
            if (!r_done && w_due) begin
                if (w_end || w_sheet) begin
                    n_done = 1'b1;
                end else if (w_next[msrs_pkg::DUE_BITS-1]) begin
                    n_start = START_MAX;
                    n_due   = {1'b0, START_MAX} + DUE_RESET;
                end else begin
                    n_start = w_next[msrs_pkg::START_BITS-1:0];
                    n_due   = w_next_due;
                end
            end
            // Return to the start of a new stream after the last beat
            if (i_last) begin
                n_pos   = '0;
                n_start = '0;
                n_due   = DUE_RESET;
                n_done  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_start <= '0;
            r_due   <= DUE_RESET;
            r_done  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_start <= n_start;
            r_due   <= n_due;
            r_done  <= n_done;
        end
    end

endmodule

### rtl/msrs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrs_fifo
// Short result queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module msrs_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msrs_pkg::t_push      i_push,
    input  logic                 i_pop,
    output msrs_pkg::t_result    o_data,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam logic [msrs_pkg::FIFO_CNT_BITS-1:0] CNT_FULL =
        msrs_pkg::FIFO_CNT_BITS'(msrs_pkg::FIFO_DEPTH);
    localparam logic [msrs_pkg::FIFO_PTR_BITS-1:0] PTR_LAST =
        msrs_pkg::FIFO_PTR_BITS'(msrs_pkg::FIFO_DEPTH - 1);

    msrs_pkg::t_result                  r_mem [msrs_pkg::FIFO_DEPTH];
    logic [msrs_pkg::FIFO_PTR_BITS-1:0] r_wr, r_rd;
    logic [msrs_pkg::FIFO_CNT_BITS-1:0] r_cnt;
    logic                               w_wr_en;
    logic                               w_rd_en;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_FULL);
    assign o_data  = r_mem[r_rd];
    assign w_wr_en = i_push.push && !o_full;
    assign w_rd_en = i_pop && !o_empty;

    // Store entry
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr_en) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_rd_en) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_wr_en, w_rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/msrs_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msrs_out
// Output register stage: pops the result queue and holds the beat until taken.
// ----------------------------------------------------------------------------
module msrs_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msrs_pkg::t_result    i_data,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output msrs_pkg::t_result    o_data
);

    logic              r_valid;
    msrs_pkg::t_result r_data;

    // Load a new beat when the register is free or being drained
    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_data;
        end
    end

endmodule

### rtl/macro_sheet_record_screen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// macro_sheet_record_screen
// Screens a workbook byte stream for old-style macro sheet records.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one stream byte per beat in tdata, tlast on the final byte.
//   Master stream: one verdict per stream; tdata carries the record offset
//   (or the stream length when the stream ended undecided), tuser carries
//   suspect (bit 0) and cause (bits 2:1).
//   Config channel: writes the 8-bit macro sheet mask; always ready. Write it
//   only while no stream is in flight.
// Throughput: one byte per cycle while the queue is not full. The record
//   chain is followed by one add and compare per beat in the front stage.
// Path: the verdict is written into the queue on the edge that accepts the
//   deciding byte, then loaded into the output register when it is free.
// Reset: synchronous, active low; clears the chain state, the queue and the
//   output register, and sets the mask to 1.
// Stall: while the master side is stalled the output register holds its
//   beat and the two-entry queue absorbs further verdicts; the slave side
//   drops tready only when the queue is full.
// ----------------------------------------------------------------------------
module macro_sheet_record_screen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,
    // Master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] record_offset
    output logic [2:0]  o_m_axis_tuser,   // [0] suspect, [2:1] cause
    // Configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data        // [7:0] macro_sheet_mask
);

    msrs_pkg::t_push   w_push;
    msrs_pkg::t_result w_q_data;
    msrs_pkg::t_result w_out_data;
    logic              w_empty;
    logic              w_full;
    logic              w_pop;
    logic              w_accept;

    assign o_s_axis_tready = !w_full;
    assign o_cfg_ready     = 1'b1;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Front: byte intake and record classification
    msrs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_data     (i_s_axis_tdata),
        .i_last     (i_s_axis_tlast),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_push     (w_push)
    );

    // Queue between front and back
    msrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_data  (w_q_data),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    // Back: output register
    msrs_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (w_q_data),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out_data)
    );

    assign o_m_axis_tdata = w_out_data.record_offset;
    assign o_m_axis_tuser = {w_out_data.cause, w_out_data.suspect};

    // A verdict is only produced by an accepted byte
    a_push_on_accept : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> w_accept)
        else $error("verdict pushed without an accepted byte");

    // The queue never takes a verdict while full
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.push |-> !w_full)
        else $error("result queue overflow");

    // Suspect is set exactly for a suspect sheet verdict
    a_suspect_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tuser[0] == (o_m_axis_tuser[2:1] == msrs_pkg::CAUSE_SHEET)))
        else $error("suspect flag disagrees with cause");

    // The output stage is empty right after reset
    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the macro sheet record screen. Workbook byte
// streams (directed record chains, then random chains, truncated chains and
// noise) are fed through the slave stream under several mask settings and
// idle/stall patterns. A behavioral screen model predicts each verdict at
// byte acceptance, and the monitor checks every verdict beat field by field.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 6;
    localparam int BYTES_PER_PHASE = 160;
    localparam int NUM_PHASES      = 5;
    localparam int MAX_BODY        = 48;
    localparam int PRINT_LIMIT     = 20;
    localparam logic [15:0] END_TYPE   = {8'h00, msrs_pkg::TYPE_END};
    localparam logic [15:0] SHEET_TYPE = {8'h00, msrs_pkg::TYPE_SHEET};
    localparam logic [msrs_pkg::POSITION_BITS-1:0] POS_MAX   = '1;
    localparam logic [msrs_pkg::START_BITS-1:0]    START_MAX = '1;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } t_beat;

    // Bench-driven signals, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [7:0]  s_data    = 8'h00;
    logic        s_last    = 1'b0;
    logic        m_ready   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = 8'h00;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;
    logic        o_cfg_ready;

    // Stimulus and expectation stores
    t_beat             stream_beats[$];
    logic [7:0]        build_buf[$];
    msrs_pkg::t_result pending_verdicts[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int mismatches     = 0;
    int quiet_cycles   = 0;
    int queued_bytes   = 0;
    int streams_built  = 0;
    int cause_seen[3]  = '{0, 0, 0};

    // Screen model state
    logic [7:0]                         scan_window[msrs_pkg::WINDOW_LEN];
    logic [msrs_pkg::POSITION_BITS-1:0] scan_pos     = '0;
    logic [msrs_pkg::START_BITS-1:0]    chain_start  = '0;
    logic                               verdict_done = 1'b0;
    logic [7:0]                         sheet_mask   = msrs_pkg::MASK_RESET;

    initial forever #1 clk = ~clk;

    macro_sheet_record_screen uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // Advance the screen model by one accepted byte; queue any verdict
    task automatic screen_byte(input logic [7:0] b, input logic last);
        logic [msrs_pkg::START_BITS-1:0] rec_start;
        logic [msrs_pkg::DUE_BITS-1:0]   due_at;
        logic [msrs_pkg::DUE_BITS-1:0]   chained;
        logic [15:0]                     rec_len;
        msrs_pkg::t_result               res;
        if (!verdict_done) begin
            for (int k = 0; k < msrs_pkg::WINDOW_LEN - 1; k++)
                scan_window[k] = scan_window[k + 1];
            scan_window[msrs_pkg::WINDOW_LEN - 1] = b;
            rec_start = chain_start;
            due_at = {1'b0, rec_start} + msrs_pkg::DUE_BITS'(msrs_pkg::LOOK_AHEAD);
            if (scan_pos != POS_MAX && {2'b00, scan_pos} == due_at) begin
                res.suspect       = 1'b0;
                res.cause         = msrs_pkg::CAUSE_END;
                res.record_offset = rec_start[msrs_pkg::OFFSET_BITS-1:0];
                if (scan_window[0] == msrs_pkg::TYPE_END && scan_window[1] == 8'h00) begin
                    pending_verdicts.push_back(res);
                    verdict_done = 1'b1;
                end else if (scan_window[0] == msrs_pkg::TYPE_SHEET &&
                             scan_window[1] == 8'h00 &&
                             (scan_window[9] & sheet_mask) != 8'h00 &&
                             scan_window[10] == msrs_pkg::SHEET_KIND &&
                             (scan_window[11] == msrs_pkg::NAME_MARK ||
                              scan_window[12] == msrs_pkg::NAME_MARK)) begin
                    res.suspect = 1'b1;
                    res.cause   = msrs_pkg::CAUSE_SHEET;
                    pending_verdicts.push_back(res);
                    verdict_done = 1'b1;
                end else begin
                    rec_len = {scan_window[3], scan_window[2]};
                    chained = {1'b0, rec_start} +
                              msrs_pkg::DUE_BITS'(msrs_pkg::HEADER_LEN) +
                              msrs_pkg::DUE_BITS'(rec_len);
                    chain_start = (chained > {1'b0, START_MAX}) ? START_MAX
                                                                : chained[msrs_pkg::START_BITS-1:0];
                end
            end
            if (!verdict_done && last) begin
                res.suspect       = 1'b0;
                res.cause         = msrs_pkg::CAUSE_STREAM;
                res.record_offset = (scan_pos != POS_MAX) ? scan_pos + 1'b1 : POS_MAX;
                pending_verdicts.push_back(res);
            end
        end
        if (scan_pos != POS_MAX)
            scan_pos = scan_pos + 1'b1;
        // Clear chain state after every stream
        if (last) begin
            foreach (scan_window[k])
                scan_window[k] = 8'h00;
            scan_pos     = '0;
            chain_start  = '0;
            verdict_done = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Stream building helpers
    task automatic put_byte(input logic [7:0] b);
        build_buf.push_back(b);
    endtask

    task automatic pad_to(input int n);
        while (build_buf.size() < n)
            put_byte(8'($urandom_range(0, 255)));
    endtask

    // Append header plus a body capped in size; long lengths break the chain
    task automatic put_record(input logic [15:0] rtype, input logic [15:0] rlen);
        put_byte(rtype[7:0]);
        put_byte(rtype[15:8]);
        put_byte(rlen[7:0]);
        put_byte(rlen[15:8]);
        repeat ((rlen > MAX_BODY) ? MAX_BODY : int'(rlen))
            put_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic put_sheet(input logic [15:0] rlen, input logic [7:0] b9,
                             input logic [7:0] b10, input logic [7:0] b11,
                             input logic [7:0] b12);
        int at;
        at = build_buf.size();
        put_record(SHEET_TYPE, rlen);
        pad_to(at + 13);
        build_buf[at + 9]  = b9;
        build_buf[at + 10] = b10;
        build_buf[at + 11] = b11;
        build_buf[at + 12] = b12;
    endtask

    // Move the built stream to the driver queue, tlast on its final byte
    task automatic flush_stream();
        t_beat bt;
        for (int k = 0; k < build_buf.size(); k++) begin
            bt.data = build_buf[k];
            bt.last = (k == build_buf.size() - 1);
            stream_beats.push_back(bt);
        end
        queued_bytes += build_buf.size();
        if (build_buf.size() != 0)
            streams_built++;
        build_buf.delete();
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (stream_beats.size() != 0 || s_valid || pending_verdicts.size() != 0);
    endtask

    task automatic write_mask(input logic [7:0] m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!o_cfg_ready)
            @(posedge clk);
        sheet_mask = m;
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Driver: present queued bytes, predict on acceptance
    always @(posedge clk) begin
        t_beat nxt;
        if (rst_n) begin
            if (s_valid && o_s_axis_tready)
                screen_byte(s_data, s_last);
            if (!s_valid || o_s_axis_tready) begin
                if (stream_beats.size() != 0 &&
                        $urandom_range(0, 99) >= send_idle_pct) begin
                    nxt = stream_beats.pop_front();
                    s_valid <= 1'b1;
                    s_data  <= nxt.data;
                    s_last  <= nxt.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each verdict beat against the oldest prediction
    always @(posedge clk) begin
        msrs_pkg::t_result want;
        if (rst_n) begin
            if (o_m_axis_tvalid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch($sformatf("unexpected verdict tuser=%0h tdata=%0d",
                                              o_m_axis_tuser, o_m_axis_tdata));
                end else begin
                    want = pending_verdicts.pop_front();
                    cause_seen[want.cause]++;
                    if (o_m_axis_tuser[0] !== want.suspect)
                        report_mismatch($sformatf("suspect got %b want %b",
                                                  o_m_axis_tuser[0], want.suspect));
                    if (o_m_axis_tuser[2:1] !== want.cause)
                        report_mismatch($sformatf("cause got %0d want %0d",
                                                  o_m_axis_tuser[2:1], want.cause));
                    if (o_m_axis_tdata !== want.record_offset)
                        report_mismatch($sformatf("record_offset got %0d want %0d",
                                                  o_m_axis_tdata, want.record_offset));
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready) ||
                    (cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("** macro_sheet_record_screen: FAILED **");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Stimulus sequence
    initial begin
        int         send_pct[NUM_PHASES];
        int         recv_pct[NUM_PHASES];
        logic [7:0] phase_mask[NUM_PHASES];
        int         target;
        int         shape;
        int         at;
        int         cut;
        int         mark;
        logic [15:0] rtype;
        logic [15:0] rlen;
        logic [7:0]  b9;
        logic [7:0]  b11;
        logic [7:0]  b12;

        send_pct   = '{0, 84, 0, 33, 0};
        recv_pct   = '{0, 0, 84, 33, 0};
        phase_mask = '{msrs_pkg::MASK_RESET, 8'hFF, 8'h00, 8'h80,
                       8'($urandom_range(1, 254))};
        foreach (scan_window[k])
            scan_window[k] = 8'h00;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // Reprogram the mask only with no stream in flight
            if (ph != 0) begin
                wait_drained();
                repeat (SETTLE_CYCLES) @(negedge clk);
                write_mask(phase_mask[ph]);
            end
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];

            if (ph == 0) begin
                // End record decided on the final byte
                put_record(END_TYPE, 16'd0);
                pad_to(15);
                flush_stream();
                // Suspect sheet, name mark in byte 11, trailing bytes dropped
                put_sheet(16'd16, 8'h01, msrs_pkg::SHEET_KIND, msrs_pkg::NAME_MARK, 8'h00);
                pad_to(30);
                flush_stream();
                // Name mark in byte 12 only
                put_sheet(16'd16, 8'hFF, msrs_pkg::SHEET_KIND, 8'h20, msrs_pkg::NAME_MARK);
                pad_to(20);
                flush_stream();
                // Mask miss: chain goes on to an end record at offset 20
                put_sheet(16'd16, 8'hFE, msrs_pkg::SHEET_KIND, msrs_pkg::NAME_MARK,
                          msrs_pkg::NAME_MARK);
                put_record(END_TYPE, 16'd2);
                pad_to(40);
                flush_stream();
                // Wrong sheet kind, stream ends undecided
                put_sheet(16'd16, 8'h01, 8'h04, msrs_pkg::NAME_MARK, msrs_pkg::NAME_MARK);
                pad_to(24);
                flush_stream();
                // No name mark
                put_sheet(16'd12, 8'h01, msrs_pkg::SHEET_KIND, 8'h00, 8'h00);
                pad_to(18);
                flush_stream();
                // End and sheet types with a nonzero high byte
                put_record(16'h010A, 16'd0);
                put_record(16'h0185, 16'd11);
                pad_to(30);
                flush_stream();
                // Single-byte stream
                put_byte(8'hFF);
                flush_stream();
                // Too short for the first record to be examined
                put_record(END_TYPE, 16'd0);
                pad_to(14);
                flush_stream();
                // Maximum record length, stream ends inside it
                put_record(16'h0001, 16'hFFFF);
                flush_stream();
                // Empty records chaining to an end record at offset 12
                repeat (3) put_record(16'h0000, 16'd0);
                put_record(END_TYPE, 16'd0);
                pad_to(27);
                flush_stream();
                // All-ones stream
                repeat (20) put_byte(8'hFF);
                flush_stream();
            end

            target = queued_bytes + BYTES_PER_PHASE;
            while (queued_bytes < target) begin
                // Now and then hold off until every verdict is back
                if ($urandom_range(0, 24) == 0)
                    wait_drained();
                shape = $urandom_range(0, 99);
                if (shape < 15) begin
                    // Noise
                    repeat ($urandom_range(1, 40)) put_byte(8'($urandom_range(0, 255)));
                end else begin
                    // Chain of ordinary records
                    repeat ($urandom_range(0, 5)) begin
                        rtype = 16'($urandom_range(0, 16'hFFFF));
                        if ($urandom_range(0, 9) == 0)
                            rtype = {8'($urandom_range(1, 255)),
                                     ($urandom_range(0, 1) != 0) ? msrs_pkg::TYPE_END
                                                                 : msrs_pkg::TYPE_SHEET};
                        else if (rtype == END_TYPE || rtype == SHEET_TYPE)
                            rtype = 16'h0001;
                        rlen = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 16'hFFFF))
                                                           : 16'($urandom_range(0, 24));
                        put_record(rtype, rlen);
                    end
                    // Deciding record candidate
                    at = build_buf.size();
                    case ($urandom_range(0, 2))
                        0: put_record(END_TYPE, 16'($urandom_range(0, 24)));
                        1: begin
                            case ($urandom_range(0, 3))
                                0: b9 = 8'h00;
                                1: b9 = 8'h01 << $urandom_range(0, 7);
                                default: b9 = 8'($urandom_range(0, 255));
                            endcase
                            mark = $urandom_range(0, 3);
                            b11 = mark[0] ? msrs_pkg::NAME_MARK : 8'($urandom_range(0, 255));
                            b12 = mark[1] ? msrs_pkg::NAME_MARK : 8'($urandom_range(0, 255));
                            put_sheet(($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 8))
                                                                 : 16'($urandom_range(9, 30)),
                                      b9,
                                      ($urandom_range(0, 3) != 0) ? msrs_pkg::SHEET_KIND
                                                                  : 8'($urandom_range(0, 255)),
                                      b11, b12);
                        end
                        default: ;
                    endcase
                    if ($urandom_range(0, 4) != 0)
                        pad_to(at + 15);
                    repeat ($urandom_range(0, 12)) put_byte(8'($urandom_range(0, 255)));
                    // Broken chains: cut short, sometimes right at the look-ahead byte
                    if (shape < 35) begin
                        cut = $urandom_range(1, build_buf.size());
                        while (build_buf.size() > cut)
                            void'(build_buf.pop_back());
                    end else if (shape < 45 && build_buf.size() > at + 15) begin
                        while (build_buf.size() > at + 15)
                            void'(build_buf.pop_back());
                    end
                end
                flush_stream();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_verdicts.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));

        $display("run: %0d streams, %0d bytes, masks 01/FF/00/80/%02h, idle and stall mixes",
                 streams_built, queued_bytes, phase_mask[NUM_PHASES-1]);
        $display("verdicts checked: %0d end record, %0d suspect sheet, %0d stream ended",
                 cause_seen[msrs_pkg::CAUSE_END], cause_seen[msrs_pkg::CAUSE_SHEET],
                 cause_seen[msrs_pkg::CAUSE_STREAM]);
        if (mismatches == 0)
            $display("** macro_sheet_record_screen: PASSED **");
        else
            $display("** macro_sheet_record_screen: FAILED **");
        $finish;
    end

endmodule
